[design/nse_pkg.sv]
// ----------------------------------------------------------------------------
// nse_pkg
// Shared types, constants and helper functions of the next-subset enumerator.
// ----------------------------------------------------------------------------
package nse_pkg;

	localparam int UNIVERSE_SIZE = 16;
	localparam int SLOTS         = 16;
	localparam int SET_W         = 16;
	localparam int ID_W          = 4;
	localparam int POS_W         = 4;
	localparam int LEN_W         = 5;
	localparam int LIST_W        = SLOTS * ID_W;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORDER_LIST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LIST_LENGTH = 1'b1;

	localparam logic [LIST_W-1:0] ORDER_LIST_RST  = 64'hFEDC_BA98_7654_3210;
	localparam logic [LEN_W-1:0]  LIST_LENGTH_RST = 5'd16;

	typedef enum logic [1:0] {
		KIND_NORMAL,
		KIND_EMPTY,
		KIND_WRAP,
		KIND_ERROR
	} kind_t;

	// decode stage result, in list-position space
	typedef struct packed {
		logic [SLOTS-1:0] mask;
		logic [LEN_W-1:0] len;
		kind_t            kind;
	} dec_t;

	// scan result: the position that advances and the packed tail behind it
	typedef struct packed {
		logic [SLOTS-1:0] mask;
		kind_t            kind;
		logic [POS_W-1:0] p;
		logic             found;
		logic [LEN_W-1:0] t;
		logic [LEN_W-1:0] card;
	} scan_t;

	function automatic logic [ID_W-1:0] slot_id(input logic [LIST_W-1:0] list,
	                                            input logic [POS_W-1:0] i);
		return list[ID_W*i +: ID_W];
	endfunction

	function automatic logic [SET_W-1:0] id_bit(input logic [ID_W-1:0] id);
		logic [SET_W-1:0] b;
		b = '0;
		if ({1'b0, id} < (ID_W+1)'(UNIVERSE_SIZE))
			b[id] = 1'b1;
		return b;
	endfunction

	// n low ones, n in 0..16
	function automatic logic [SLOTS-1:0] ones(input logic [LEN_W-1:0] n);
		logic [SLOTS:0] w;
		w = ((SLOTS+1)'(1) << n) - (SLOTS+1)'(1);
		return w[SLOTS-1:0];
	endfunction

endpackage

[design/nse_decode.sv]
// ----------------------------------------------------------------------------
// nse_decode
// First stage: maps input members onto order-list positions and classifies
// the request as empty, out-of-list or ordinary.
// ----------------------------------------------------------------------------
module nse_decode import nse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SET_W-1:0]  subset,
	input  logic [LIST_W-1:0] order_list,
	input  logic [LEN_W-1:0]  len,
	output logic              out_valid,
	input  logic              out_ready,
	output dec_t              out_data
);

	logic             valid_s1;
	dec_t             data_s1;
	logic [SLOTS-1:0] mask;
	logic [SET_W-1:0] covered;
	logic [SET_W-1:0] b;
	kind_t            kind;

	always_comb begin
		mask    = '0;
		covered = '0;
		b       = '0;
		for (int i = 0; i < SLOTS; i++) begin
			b = id_bit(slot_id(order_list, POS_W'(i)));
			if (LEN_W'(i) < len) begin
				covered = covered | b;
				mask[i] = |(subset & b);
			end
		end
		if ((subset & ~covered) != '0)
			kind = KIND_ERROR;
		else if (subset == '0)
			kind = KIND_EMPTY;
		else
			kind = KIND_NORMAL;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.mask <= mask;
			data_s1.len  <= len;
			data_s1.kind <= kind;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

[design/nse_scan.sv]
// ----------------------------------------------------------------------------
// nse_scan
// Two stages: find the highest free list position and count members, then
// find the member just below that free position, which is the one to advance.
// ----------------------------------------------------------------------------
module nse_scan import nse_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  dec_t  in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output scan_t out_data
);

	typedef struct packed {
		logic [SLOTS-1:0] mask;
		logic [LEN_W-1:0] len;
		kind_t            kind;
		logic [POS_W-1:0] z;
		logic [LEN_W-1:0] card;
	} free_t;

	logic             valid_s2;
	logic             valid_s3;
	free_t            data_s2;
	scan_t            data_s3;
	logic             ready_s2;
	logic [SLOTS-1:0] occ;
	logic [POS_W-1:0] z;
	logic             z_found;
	logic [LEN_W-1:0] card;
	kind_t            kind2;
	logic [SLOTS-1:0] below;
	logic [POS_W-1:0] p;
	logic             p_found;
	logic [LEN_W-1:0] t;

	// stage 2: positions past the list length count as taken
	always_comb begin
		occ     = in_data.mask | ~ones(in_data.len);
		z       = '0;
		z_found = 1'b0;
		card    = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!occ[i]) begin
				z       = POS_W'(i);
				z_found = 1'b1;
			end
			card = card + LEN_W'(in_data.mask[i]);
		end
		kind2 = in_data.kind;
		if (in_data.kind == KIND_NORMAL && !z_found)
			kind2 = KIND_WRAP;
	end

	// stage 3: members from z upward form the packed tail
	always_comb begin
		below   = data_s2.mask & ones({1'b0, data_s2.z});
		p       = '0;
		p_found = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (below[i]) begin
				p       = POS_W'(i);
				p_found = 1'b1;
			end
		end
		t = data_s2.len - LEN_W'(1) - {1'b0, data_s2.z};
	end

	assign ready_s2 = !valid_s3 || out_ready;
	assign in_ready = !valid_s2 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s2 <= in_valid;
			if (ready_s2)
				valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2.mask <= in_data.mask;
			data_s2.len  <= in_data.len;
			data_s2.kind <= kind2;
			data_s2.z    <= z;
			data_s2.card <= card;
		end
		if (ready_s2 && valid_s2) begin
			data_s3.mask  <= data_s2.mask;
			data_s3.kind  <= data_s2.kind;
			data_s3.p     <= p;
			data_s3.found <= p_found;
			data_s3.t     <= t;
			data_s3.card  <= data_s2.card;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

[design/nse_pack.sv]
// ----------------------------------------------------------------------------
// nse_pack
// Two stages: build the new list-position mask, then map positions back to
// element ids into the output register.
// ----------------------------------------------------------------------------
module nse_pack import nse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  scan_t             in_data,
	input  logic [LIST_W-1:0] order_list,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SET_W-1:0]  next_subset,
	output logic              wrapped,
	output logic              not_in_list
);

	logic             valid_s4;
	logic             valid_s5;
	logic [SLOTS-1:0] pos_s4;
	logic             wrap_s4;
	logic             err_s4;
	logic [SET_W-1:0] subset_s5;
	logic             wrap_s5;
	logic             err_s5;
	logic             ready_s4;
	logic [SLOTS-1:0] pos_mask;
	logic [31:0]      tail;
	logic [SET_W-1:0] elems;

	always_comb begin
		tail = 32'(ones(in_data.t + LEN_W'(1))) << ({1'b0, in_data.p} + 5'd1);
		case (in_data.kind)
			KIND_EMPTY: pos_mask = SLOTS'(1);
			KIND_WRAP,
			KIND_ERROR: pos_mask = '0;
			default: begin
				if (in_data.found)
					pos_mask = (in_data.mask & ones({1'b0, in_data.p})) | tail[SLOTS-1:0];
				else
					pos_mask = ones(in_data.card + LEN_W'(1));
			end
		endcase
	end

	always_comb begin
		elems = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (pos_s4[i])
				elems = elems | id_bit(slot_id(order_list, POS_W'(i)));
		end
	end

	assign ready_s4 = !valid_s5 || out_ready;
	assign in_ready = !valid_s4 || ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s4 <= in_valid;
			if (ready_s4)
				valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pos_s4  <= pos_mask;
			wrap_s4 <= (in_data.kind == KIND_WRAP);
			err_s4  <= (in_data.kind == KIND_ERROR);
		end
		if (ready_s4 && valid_s4) begin
			subset_s5 <= elems;
			wrap_s5   <= wrap_s4;
			err_s5    <= err_s4;
		end
	end

	assign out_valid   = valid_s5;
	assign next_subset = subset_s5;
	assign wrapped     = wrap_s5;
	assign not_in_list = err_s5;

endmodule

[design/next_subset_enumerator_core.sv]
// ----------------------------------------------------------------------------
// next_subset_enumerator_core
// Steps a subset bitmask to its successor in cardinality-then-list order.
// ----------------------------------------------------------------------------
// A stream of subset masks goes in and one successor mask comes out for each.
// The block takes one request per clock while not stalled and passes it
// through five register stages: position decode, free-slot search and
// member count, advance-point search, new position mask, and element
// mapping into the output register. Back-pressure on the result side stalls
// the whole pipeline in place. The user must write order_list and
// list_length on the cfg port only while no request is in flight; the block
// does not enforce it. list_length 0 acts as 1 and values above 16 act as 16.
module next_subset_enumerator_core import nse_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,   // [15:0] current_subset
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [15:0]           m_axis_tdata,   // [15:0] next_subset
	output logic [1:0]            m_axis_tuser,   // [0] wrapped, [1] not_in_list
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [LIST_W-1:0] order_list_q;
	logic [LEN_W-1:0]  list_length_q;
	logic [LEN_W-1:0]  len_eff;
	logic              dec_valid;
	logic              dec_ready;
	dec_t              dec_data;
	logic              scan_valid;
	logic              scan_ready;
	scan_t             scan_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_list_q  <= ORDER_LIST_RST;
			list_length_q <= LIST_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORDER_LIST:  order_list_q  <= cfg_data[LIST_W-1:0];
				REG_LIST_LENGTH: list_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (list_length_q == '0)
			len_eff = LEN_W'(1);
		else if (list_length_q > LEN_W'(SLOTS))
			len_eff = LEN_W'(SLOTS);
		else
			len_eff = list_length_q;
	end

	nse_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.subset     (s_axis_tdata),
		.order_list (order_list_q),
		.len        (len_eff),
		.out_valid  (dec_valid),
		.out_ready  (dec_ready),
		.out_data   (dec_data)
	);

	nse_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_data   (dec_data),
		.out_valid (scan_valid),
		.out_ready (scan_ready),
		.out_data  (scan_data)
	);

	nse_pack u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (scan_valid),
		.in_ready    (scan_ready),
		.in_data     (scan_data),
		.order_list  (order_list_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.next_subset (m_axis_tdata),
		.wrapped     (m_axis_tuser[0]),
		.not_in_list (m_axis_tuser[1])
	);

	// a result is never both a wrap and an out-of-list error
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("wrapped and not_in_list both set");

	// flagged results carry an empty subset
	a_flag_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1])) |-> (m_axis_tdata == '0))
		else $error("flagged result with non-empty subset");

	// input side only stalls when the pipeline is full and the output is held
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output back-pressure");

endmodule

[tb/sv/tb_next_subset_enumerator_core.sv]
// ----------------------------------------------------------------------------
// tb_next_subset_enumerator_core
// Streams subset masks through the enumerator and checks every successor.
// ----------------------------------------------------------------------------
// A short directed table covers the corners of the order list: empty and full
// inputs, members outside the list, clamped lengths and repeated ids. Random
// phases then reload order_list and list_length and send enumeration walks,
// subsets packed at the top of the list, full lists and raw noise, under
// changing back-pressure on both streams. Each result is compared with a local
// successor function or, for typed table rows, with the row's fixed answer.
module tb_next_subset_enumerator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import nse_pkg::*;

	localparam int HOLD_CYCLES     = 300;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int RAND_PHASES     = 12;
	localparam int ITEMS_PER_PHASE = 90;
	localparam int REPORT_MAX      = 10;
	localparam int SETTLE_CYCLES   = 8;

	typedef struct packed {
		logic [15:0] nxt;
		logic        wrapped;
		logic        not_in_list;
	} succ_t;

	// one row: either a register load or a request, with an optional fixed answer
	typedef struct packed {
		logic        is_cfg;
		logic [63:0] lst;
		logic [4:0]  len;
		logic [15:0] cur;
		logic        typed;
		succ_t       want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata = '0;    // [15:0] current_subset
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [15:0]           m_axis_tdata;         // [15:0] next_subset
	logic [1:0]            m_axis_tuser;         // [0] wrapped, [1] not_in_list
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_ORDER_LIST;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [63:0] list_model = ORDER_LIST_RST;
	logic [4:0]  len_model = LIST_LENGTH_RST;
	int          src_idle_pct = 0;
	int          dst_idle_pct = 0;
	int          hold_asked = 0;
	int          hold_served = 0;
	int          hold_left = 0;
	int          mismatch_cnt = 0;
	int          cycle_cnt = 0;
	succ_t       pending_succ[$];

	dir_row_t dir_tab [26] = '{
		'{1'b0, 64'h0, 5'd0, 16'h0000, 1'b1, '{16'h0001, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'hFFFF, 1'b1, '{16'h0000, 1'b1, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h0001, 1'b1, '{16'h0002, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h8000, 1'b1, '{16'h0003, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'hC000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h7FFF, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'hAAAA, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h5555, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h0F0F, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h1234, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		// short list: only elements 0..3 are members
		'{1'b1, 64'hFEDC_BA98_7654_3210, 5'd4, 16'h0, 1'b0, '{16'h0, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h0010, 1'b1, '{16'h0000, 1'b0, 1'b1}},
		'{1'b0, 64'h0, 5'd0, 16'h8000, 1'b1, '{16'h0000, 1'b0, 1'b1}},
		'{1'b0, 64'h0, 5'd0, 16'h000F, 1'b1, '{16'h0000, 1'b1, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h0000, 1'b1, '{16'h0001, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h000A, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		// length zero behaves as a one-entry list holding element 15
		'{1'b1, 64'h0123_4567_89AB_CDEF, 5'd0, 16'h0, 1'b0, '{16'h0, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h8000, 1'b1, '{16'h0000, 1'b1, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h0000, 1'b1, '{16'h8000, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h0001, 1'b1, '{16'h0000, 1'b0, 1'b1}},
		// oversized length, every slot holds element 0
		'{1'b1, 64'h0, 5'd31, 16'h0, 1'b0, '{16'h0, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h0001, 1'b1, '{16'h0000, 1'b1, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h0002, 1'b1, '{16'h0000, 1'b0, 1'b1}},
		// repeated ids: four slots of element 0, four of element 1
		'{1'b1, 64'h0000_0000_1111_0000, 5'd8, 16'h0, 1'b0, '{16'h0, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h0001, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{1'b0, 64'h0, 5'd0, 16'h0003, 1'b0, '{16'h0000, 1'b0, 1'b0}}
	};

	next_subset_enumerator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int list_span(input logic [4:0] len);
		if (len == 5'd0)
			return 1;
		if (len > 5'(SLOTS))
			return SLOTS;
		return int'(len);
	endfunction

	function automatic logic [15:0] slot_member(input logic [63:0] lst, input int j);
		logic [3:0] id;
		id = lst[4*j +: 4];
		return (int'(id) < UNIVERSE_SIZE) ? (16'd1 << id) : 16'd0;
	endfunction

	function automatic succ_t successor_of(input logic [15:0] cur, input logic [63:0] lst,
	                                       input logic [4:0] len);
		succ_t       r;
		logic [15:0] covered;
		int          n, card, lim;
		int          at [16];
		r = '0;
		covered = '0;
		card = 0;
		n = list_span(len);
		for (int i = 0; i < n; i++)
			covered |= slot_member(lst, i);
		if ((cur & ~covered) != 16'd0) begin
			r.not_in_list = 1'b1;
			return r;
		end
		if (cur == 16'd0) begin
			r.nxt = slot_member(lst, 0);
			return r;
		end
		// membership is per list position, so a repeated id fills several
		for (int i = 0; i < n; i++) begin
			if ((cur & slot_member(lst, i)) != 16'd0) begin
				at[card] = i;
				card++;
			end
		end
		if (card >= n) begin
			r.wrapped = 1'b1;
			return r;
		end
		for (int k = card - 1; k >= 0; k--) begin
			lim = n - (card - k);
			if (at[k] < lim) begin
				at[k]++;
				for (int j = k + 1; j < card; j++)
					at[j] = at[j-1] + 1;
				for (int j = 0; j < card; j++)
					r.nxt |= slot_member(lst, at[j]);
				return r;
			end
		end
		// nothing can advance: first card+1 entries
		for (int j = 0; j < card + 1 && j < n; j++)
			r.nxt |= slot_member(lst, j);
		return r;
	endfunction

	// called at a falling edge, returns at a falling edge with tvalid still high
	task automatic push_subset(input logic [15:0] cur, input logic typed, input succ_t want);
		succ_t exp_succ;
		exp_succ = typed ? want : successor_of(cur, list_model, len_model);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= cur;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_succ.push_back(exp_succ);
		@(negedge clk);
	endtask

	task automatic settle_pipeline();
		while (pending_succ.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_config(input logic [63:0] lst, input logic [4:0] len);
		cfg_valid <= 1'b1;
		cfg_index <= REG_ORDER_LIST;
		cfg_data  <= lst;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		list_model = lst;
		@(negedge clk);
		cfg_index <= REG_LIST_LENGTH;
		cfg_data  <= CFG_DATA_W'(len);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		len_model = len;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result side: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
	end

	always @(posedge clk) begin
		succ_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.nxt         = m_axis_tdata;
			got.wrapped     = m_axis_tuser[0];
			got.not_in_list = m_axis_tuser[1];
			if (pending_succ.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= REPORT_MAX)
					$display("unexpected result: next %h wrapped %b not_in_list %b",
					         got.nxt, got.wrapped, got.not_in_list);
			end else begin
				want = pending_succ.pop_front();
				if (got.nxt != want.nxt || got.wrapped != want.wrapped ||
				    got.not_in_list != want.not_in_list) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_MAX)
						$display("mismatch: expected next %h wrapped %b not_in_list %b, got %h %b %b",
						         want.nxt, want.wrapped, want.not_in_list,
						         got.nxt, got.wrapped, got.not_in_list);
				end
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [63:0] lst;
		logic [4:0]  len;
		logic [15:0] cur, covered, chain;
		logic [3:0]  deck [16];
		logic [3:0]  tmp;
		succ_t       step;
		int          sel, n, c;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 24;
		dst_idle_pct = 86;
		for (int r = 0; r < $size(dir_tab); r++) begin
			if (dir_tab[r].is_cfg) begin
				s_axis_tvalid <= 1'b0;
				settle_pipeline();
				load_config(dir_tab[r].lst, dir_tab[r].len);
			end else
				push_subset(dir_tab[r].cur, dir_tab[r].typed, dir_tab[r].want);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			s_axis_tvalid <= 1'b0;
			settle_pipeline();
			case (ph / 4)
				0: begin
					src_idle_pct = 24;
					dst_idle_pct = 86;
				end
				1: begin
					src_idle_pct = 86;
					dst_idle_pct = 24;
				end
				default: begin
					src_idle_pct = 0;
					dst_idle_pct = 0;
				end
			endcase

			for (int j = 0; j < 16; j++)
				deck[j] = 4'(j);
			for (int j = 15; j > 0; j--) begin
				c = $urandom_range(0, j);
				tmp = deck[j];
				deck[j] = deck[c];
				deck[c] = tmp;
			end
			for (int j = 0; j < 16; j++)
				lst[4*j +: 4] = deck[j];
			case (ph % 6)
				0: begin
					lst = ORDER_LIST_RST;
					len = LIST_LENGTH_RST;
				end
				1: len = 5'($urandom_range(1, 16));
				2: begin
					lst = {$urandom, $urandom};
					len = 5'($urandom_range(0, 31));
				end
				3: len = 5'd1;
				4: begin
					// few distinct ids, lots of repeats
					for (int j = 0; j < 16; j++)
						lst[4*j +: 4] = 4'($urandom_range(0, 3));
					len = 5'($urandom_range(2, 16));
				end
				default: len = 5'($urandom_range(17, 31));
			endcase
			load_config(lst, len);
			if (ph == 8)
				hold_asked++;

			n = list_span(len_model);
			covered = '0;
			for (int j = 0; j < n; j++)
				covered |= slot_member(list_model, j);
			chain = '0;

			for (int it = 0; it < ITEMS_PER_PHASE; it++) begin
				sel = $urandom_range(0, 99);
				if (sel < 35)
					cur = chain;                 // follow the enumeration
				else if (sel < 70) begin
					cur = 16'($urandom);
					case ($urandom_range(0, 2))
						0: cur &= 16'($urandom);
						1: cur |= 16'($urandom);
						default: ;
					endcase
					cur &= covered;
				end else if (sel < 82) begin
					// members packed at the tail of the list
					cur = '0;
					c = $urandom_range(1, n);
					for (int j = n - c; j < n; j++)
						cur |= slot_member(list_model, j);
				end else if (sel < 90) begin
					cur = covered;
					if ($urandom_range(0, 1))
						cur[$urandom_range(0, 15)] = 1'b0;
				end else
					cur = 16'($urandom_range(0, 65535));
				push_subset(cur, 1'b0, '0);
				step = successor_of(cur, list_model, len_model);
				chain = step.nxt;
			end
		end

		s_axis_tvalid <= 1'b0;
		settle_pipeline();
		if (mismatch_cnt == 0 && pending_succ.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
design/nse_pkg.sv
design/nse_decode.sv
design/nse_scan.sv
design/nse_pack.sv
design/next_subset_enumerator_core.sv
tb/sv/tb_next_subset_enumerator_core.sv
